>>> design/lwn_pkg.sv
// Package for the local window neuron: item and register types, register map,
// defaults, and the constant functions that build the sigmoid table.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package lwn_pkg;

    // Default sizing, handed to the top level parameters.
    localparam int MAX_TAPS_DEF        = 64;
    localparam int SIGMOID_ENTRIES_DEF = 256;

    // Fixed field widths.
    localparam int ACT_W   = 16;
    localparam int WGT_W   = 16;
    localparam int PROD_W  = 33;
    localparam int ACC_W   = 40;
    localparam int TAPS_W  = 7;
    localparam int NEUR_W  = 16;
    localparam int BIAS_W  = 24;
    localparam int X_W     = 29;
    localparam int FRAC_SH = 12;

    // Register map: one 32-bit word per register.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_TAPS          = 2'd0;
    localparam logic [1:0] REG_LAYER_NEURONS = 2'd1;
    localparam logic [1:0] REG_BIAS_Q16      = 2'd2;

    // Register reset values (bias is 0.1 in Q8.16).
    localparam logic [TAPS_W-1:0] TAPS_RST          = 7'd3;
    localparam logic [NEUR_W-1:0] LAYER_NEURONS_RST = 16'd1024;
    localparam logic [BIAS_W-1:0] BIAS_Q16_RST      = 24'd6554;

    // Output queue sizing.
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = 3;
    localparam int Q_CW    = 4;

    typedef struct packed {
        logic [ACT_W-1:0] activation_in;
        logic [WGT_W-1:0] weight;
    } t_in_item;

    typedef struct packed {
        logic [ACT_W-1:0] activation_out;
        logic             last_of_layer;
    } t_out_item;

    typedef struct packed {
        logic [TAPS_W-1:0] taps;
        logic [NEUR_W-1:0] layer_neurons;
        logic [BIAS_W-1:0] bias_q16;
    } t_cfg;

    // Occupancy of the pipeline after the coming clock edge.
    typedef struct packed {
        logic s1_next;
        logic s2_next;
        logic s3_next;
    } t_pipe_status;

    // Restoring long division, used only while elaborating the sigmoid table.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-num/den) in Q.31: a short Taylor series of exp(-t/256),
    // then squared eight times with rounding.
    function automatic logic [63:0] exp_neg_q31(input logic [63:0] num, input logic [63:0] den);
        logic [63:0]        y;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        y    = udiv64((num << 23) + (den >> 1), den);
        sum  = 64'sd2147483648;
        term = 64'd2147483648;
        for (int n = 1; n <= 8; n++) begin
            term = udiv64((term * y) >> 31, 64'(n));
            if ((n % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        v = $unsigned(sum);
        for (int i = 0; i < 8; i++) begin
            v = (v * v + 64'd1073741824) >> 31;
        end
        return v;
    endfunction

    // One sigmoid table entry, taken at the left edge of its bin over [-8,8).
    function automatic logic [15:0] sig_entry(input logic [63:0] k, input logic [63:0] entries);
        logic [63:0] pos;
        logic [63:0] half;
        logic        nonneg;
        logic [63:0] num;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] top;
        logic [63:0] r;
        pos    = 64'd16 * k;
        half   = 64'd8 * entries;
        nonneg = (pos >= half);
        num    = nonneg ? (pos - half) : (half - pos);
        e      = exp_neg_q31(num, entries);
        d      = 64'd2147483648 + e;
        top    = nonneg ? (64'd65536 << 31) : (64'd65536 * e);
        r      = udiv64(top + (d >> 1), d);
        if (r > 64'd65535) begin
            r = 64'd65535;
        end
        return r[15:0];
    endfunction

endpackage

>>> design/lwn_cfg.sv
// Configuration registers of the local window neuron behind an APB-style port.
// Depends on lwn_pkg for the register map, reset values and t_cfg.
`timescale 1ns / 1ps

module lwn_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lwn_pkg::PADDR_W-1:0] paddr,
    input  logic [lwn_pkg::PDATA_W-1:0] pwdata,
    output logic [lwn_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output lwn_pkg::t_cfg               o_cfg
);

    lwn_pkg::t_cfg r_cfg;
    lwn_pkg::t_cfg n_cfg;
    logic          w_wr;
    logic [1:0]    w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[3:2];

    // Register write decode; writes beyond the map are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_reg)
                lwn_pkg::REG_TAPS:          n_cfg.taps = pwdata[lwn_pkg::TAPS_W-1:0];
                lwn_pkg::REG_LAYER_NEURONS: n_cfg.layer_neurons = pwdata[lwn_pkg::NEUR_W-1:0];
                lwn_pkg::REG_BIAS_Q16:      n_cfg.bias_q16 = pwdata[lwn_pkg::BIAS_W-1:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.taps          <= lwn_pkg::TAPS_RST;
            r_cfg.layer_neurons <= lwn_pkg::LAYER_NEURONS_RST;
            r_cfg.bias_q16      <= lwn_pkg::BIAS_Q16_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read back, zero extended.
    always_comb begin
        case (w_reg)
            lwn_pkg::REG_TAPS:          prdata = lwn_pkg::PDATA_W'(r_cfg.taps);
            lwn_pkg::REG_LAYER_NEURONS: prdata = lwn_pkg::PDATA_W'(r_cfg.layer_neurons);
            lwn_pkg::REG_BIAS_Q16:      prdata = lwn_pkg::PDATA_W'(r_cfg.bias_q16);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/lwn_mac.sv
// Front of the neuron pipeline: tap and neuron counters, the product register
// and the 40-bit accumulator. Depends on lwn_pkg.
`timescale 1ns / 1ps

module lwn_mac #(
    parameter int MAX_TAPS = lwn_pkg::MAX_TAPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  lwn_pkg::t_in_item          i_item,
    input  lwn_pkg::t_cfg              i_cfg,
    output logic                       o_fin_valid,
    output logic [lwn_pkg::ACC_W-1:0]  o_fin_sum,
    output logic                       o_fin_last,
    output lwn_pkg::t_pipe_status      o_status
);

    localparam int CNT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int ETW   = $clog2(MAX_TAPS + 1);
    localparam int CMP_W = ((ETW > lwn_pkg::TAPS_W) ? ETW : lwn_pkg::TAPS_W) + 1;

    logic [CNT_W-1:0]                r_tap_count;
    logic [lwn_pkg::NEUR_W-1:0]      r_neuron_count;
    logic                            r_s1_valid;
    logic                            r_s1_end;
    logic                            r_s1_last;
    logic signed [lwn_pkg::PROD_W-1:0] r_s1_prod;
    logic [lwn_pkg::ACC_W-1:0]       r_acc;
    logic                            r_s2_valid;
    logic [lwn_pkg::ACC_W-1:0]       r_s2_sum;
    logic                            r_s2_last;

    logic [CMP_W-1:0]                w_taps;
    logic [CMP_W-1:0]                w_eff_taps;
    logic [CMP_W-1:0]                w_next_tap;
    logic                            w_end;
    logic [lwn_pkg::NEUR_W-1:0]      w_eff_neurons;
    logic [lwn_pkg::NEUR_W:0]        w_next_neuron;
    logic                            w_last;
    logic signed [lwn_pkg::PROD_W-1:0] w_prod;
    logic [lwn_pkg::ACC_W-1:0]       w_sum;

    // Effective tap count: zero counts as one, large values clip to MAX_TAPS.
    assign w_taps = CMP_W'(i_cfg.taps);
    always_comb begin
        if (w_taps == '0) begin
            w_eff_taps = CMP_W'(1);
        end else if (w_taps > CMP_W'(MAX_TAPS)) begin
            w_eff_taps = CMP_W'(MAX_TAPS);
        end else begin
            w_eff_taps = w_taps;
        end
    end
    assign w_next_tap = CMP_W'(r_tap_count) + CMP_W'(1);
    assign w_end      = (w_next_tap >= w_eff_taps);

    // Last output of the layer; a zero neuron count flags every output.
    assign w_eff_neurons = (i_cfg.layer_neurons == '0) ? lwn_pkg::NEUR_W'(1)
                                                       : i_cfg.layer_neurons;
    assign w_next_neuron = {1'b0, r_neuron_count} + (lwn_pkg::NEUR_W + 1)'(1);
    assign w_last        = (w_next_neuron >= {1'b0, w_eff_neurons});

    // Unsigned Q0.16 activation times signed Q4.12 weight.
    assign w_prod = $signed({1'b0, i_item.activation_in}) * $signed(i_item.weight);

    // Counters advance on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count    <= '0;
            r_neuron_count <= '0;
        end else if (i_accept) begin
            if (w_end) begin
                r_tap_count <= '0;
                if (w_last) begin
                    r_neuron_count <= '0;
                end else begin
                    r_neuron_count <= w_next_neuron[lwn_pkg::NEUR_W-1:0];
                end
            end else begin
                r_tap_count <= w_next_tap[CNT_W-1:0];
            end
        end
    end

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_prod <= w_prod;
            r_s1_end  <= w_end;
            r_s1_last <= w_end && w_last;
        end
    end

    // Accumulate stage; the sum wraps at 40 bits and clears after the last tap.
    assign w_sum = r_acc + {{(lwn_pkg::ACC_W - lwn_pkg::PROD_W){r_s1_prod[lwn_pkg::PROD_W-1]}},
                            r_s1_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_end;
            if (r_s1_valid) begin
                r_acc <= r_s1_end ? '0 : w_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_end) begin
            r_s2_sum  <= w_sum;
            r_s2_last <= r_s1_last;
        end
    end

    assign o_fin_valid = r_s2_valid;
    assign o_fin_sum   = r_s2_sum;
    assign o_fin_last  = r_s2_last;

    assign o_status.s1_next = i_accept;
    assign o_status.s2_next = r_s1_valid && r_s1_end;
    assign o_status.s3_next = r_s2_valid;

endmodule

>>> design/lwn_act.sv
// Activation stage: Q.16 scaling, bias add, sigmoid table index and lookup.
// Depends on lwn_pkg for widths, t_out_item and the table entry function.
`timescale 1ns / 1ps

module lwn_act #(
    parameter int SIGMOID_ENTRIES = lwn_pkg::SIGMOID_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [lwn_pkg::ACC_W-1:0]  i_sum,
    input  logic                       i_last,
    input  logic [lwn_pkg::BIAS_W-1:0] i_bias,
    output logic                       o_valid,
    output lwn_pkg::t_out_item         o_item
);

    localparam int IW = $clog2(SIGMOID_ENTRIES);
    localparam int SW = IW + 21;
    localparam logic signed [lwn_pkg::X_W-1:0] X_LO = -29'sd524288;
    localparam logic signed [lwn_pkg::X_W-1:0] X_HI = 29'sd524288;

    logic [15:0]                       w_rom [SIGMOID_ENTRIES];
    logic signed [lwn_pkg::X_W-1:0]    w_x;
    logic [lwn_pkg::X_W-1:0]           w_xo;
    logic [SW-1:0]                     w_scaled;
    logic [IW-1:0]                     w_idx;
    logic                              r_s3_valid;
    logic [IW-1:0]                     r_idx;
    logic                              r_last;

    // Sigmoid table, built at elaboration.
    for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_rom
        localparam logic [15:0] ENTRY = lwn_pkg::sig_entry(64'(k), 64'(SIGMOID_ENTRIES));
        assign w_rom[k] = ENTRY;
    end

    // Floor shift by 12 to Q.16, then the signed Q8.16 bias.
    assign w_x = $signed({i_sum[lwn_pkg::ACC_W-1], i_sum[lwn_pkg::ACC_W-1:lwn_pkg::FRAC_SH]})
               + $signed({{(lwn_pkg::X_W - lwn_pkg::BIAS_W){i_bias[lwn_pkg::BIAS_W-1]}},
                          i_bias});

    // Bin index over [-8,8), saturated at both ends.
    assign w_xo     = $unsigned(w_x - X_LO);
    assign w_scaled = SW'(w_xo[19:0]) * SW'(SIGMOID_ENTRIES);
    always_comb begin
        if (w_x < X_LO) begin
            w_idx = '0;
        end else if (w_x >= X_HI) begin
            w_idx = IW'(SIGMOID_ENTRIES - 1);
        end else begin
            w_idx = w_scaled[20 +: IW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_idx  <= w_idx;
            r_last <= i_last;
        end
    end

    // Table read feeds the output queue directly.
    assign o_valid               = r_s3_valid;
    assign o_item.activation_out = w_rom[r_idx];
    assign o_item.last_of_layer  = r_last;

endmodule

>>> design/lwn_outq.sv
// Output queue of the neuron: holds finished items and throttles the input
// so that every item in the pipeline has a free slot. Depends on lwn_pkg.
`timescale 1ns / 1ps

module lwn_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lwn_pkg::t_out_item    i_item,
    input  lwn_pkg::t_pipe_status i_status,
    input  logic                  i_stall,
    output logic                  o_valid,
    output lwn_pkg::t_out_item    o_item,
    output logic                  o_in_stall
);

    lwn_pkg::t_out_item        r_q [lwn_pkg::Q_DEPTH];
    logic [lwn_pkg::Q_AW-1:0]  r_wr_ptr;
    logic [lwn_pkg::Q_AW-1:0]  r_rd_ptr;
    logic [lwn_pkg::Q_CW-1:0]  r_count;
    logic [lwn_pkg::Q_CW-1:0]  n_count;
    logic [lwn_pkg::Q_CW-1:0]  n_pending;
    logic                      r_stall;
    logic                      w_pop;

    assign w_pop   = (r_count != '0) && !i_stall;
    assign n_count = r_count + lwn_pkg::Q_CW'(i_push) - lwn_pkg::Q_CW'(w_pop);

    // Items queued plus items still in the pipeline after this edge.
    assign n_pending = n_count + lwn_pkg::Q_CW'(i_status.s1_next)
                     + lwn_pkg::Q_CW'(i_status.s2_next)
                     + lwn_pkg::Q_CW'(i_status.s3_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_stall  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_stall <= (n_pending >= lwn_pkg::Q_CW'(lwn_pkg::Q_DEPTH));
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + lwn_pkg::Q_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + lwn_pkg::Q_AW'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_item;
        end
    end

    assign o_valid    = (r_count != '0);
    assign o_item     = r_q[r_rd_ptr];
    assign o_in_stall = r_stall;

endmodule

>>> design/local_window_neuron_mac_sigmoid.sv
// Streaming neuron of a locally connected layer: one activation/weight pair
// is taken per clock while o_in_stall is low. Each pair is multiplied (unsigned
// Q0.16 by signed Q4.12) and summed in a 40-bit accumulator; after the
// configured number of taps the sum is floored to Q.16, the Q8.16 bias is
// added and a rounded sigmoid table over [-8,8) gives one Q0.16 activation,
// flagged on the layer's last neuron. The pipeline has three register stages
// (product, sum, table index) between an accepted pair and the output queue.
// The 8-entry output queue absorbs downstream stalls; the input stalls only
// when the queue together with the items in flight could fill it. Write the
// configuration registers (taps at 0x0, layer_neurons at 0x4, bias_q16 at 0x8)
// only while no neuron is in progress and all results have been taken.
// Depends on lwn_pkg, lwn_cfg, lwn_mac, lwn_act and lwn_outq.
`timescale 1ns / 1ps

module local_window_neuron_mac_sigmoid #(
    parameter int MAX_TAPS        = lwn_pkg::MAX_TAPS_DEF,
    parameter int SIGMOID_ENTRIES = lwn_pkg::SIGMOID_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  lwn_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output lwn_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lwn_pkg::PADDR_W-1:0] paddr,
    input  logic [lwn_pkg::PDATA_W-1:0] pwdata,
    output logic [lwn_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    lwn_pkg::t_cfg             w_cfg;
    lwn_pkg::t_pipe_status     w_status;
    lwn_pkg::t_out_item        w_act_item;
    logic                      w_accept;
    logic                      w_fin_valid;
    logic [lwn_pkg::ACC_W-1:0] w_fin_sum;
    logic                      w_fin_last;
    logic                      w_act_valid;

    // An item enters whenever it is offered and the queue has room for it.
    assign w_accept = i_in_valid && !o_in_stall;

    lwn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lwn_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_in_data),
        .i_cfg       (w_cfg),
        .o_fin_valid (w_fin_valid),
        .o_fin_sum   (w_fin_sum),
        .o_fin_last  (w_fin_last),
        .o_status    (w_status)
    );

    lwn_act #(
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
    ) u_act (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fin_valid),
        .i_sum   (w_fin_sum),
        .i_last  (w_fin_last),
        .i_bias  (w_cfg.bias_q16),
        .o_valid (w_act_valid),
        .o_item  (w_act_item)
    );

    lwn_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_act_valid),
        .i_item     (w_act_item),
        .i_status   (w_status),
        .i_stall    (i_out_stall),
        .o_valid    (o_out_valid),
        .o_item     (o_out_data),
        .o_in_stall (o_in_stall)
    );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for local_window_neuron_mac_sigmoid: streams
// activation/weight pairs under random idling and checks each activation out.
// Depends on lwn_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import lwn_pkg::*;

    localparam int LUT_N         = SIGMOID_ENTRIES_DEF;
    localparam int TAPS_CAP      = MAX_TAPS_DEF;
    localparam longint X_EDGE    = 64'sd524288;  // 8.0 in Q.16
    localparam int TAPS_AT_RST   = 3;
    localparam int NEURONS_AT_RST = 1024;
    localparam int BIAS_AT_RST   = 6554;
    localparam int SETTLE        = 6;
    localparam int HANG_LIMIT    = 2000;
    localparam int ITEM_GOAL     = 1050;
    localparam int WAIT_MAX      = 12;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [PDATA_W-1:0]   pwdata      = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Shadow of the neuron: accumulator, counters, registers and sigmoid table.
    logic [15:0]          sig_lut [LUT_N];
    logic [ACC_W-1:0]     mac_sum;
    int unsigned          taps_done;
    int unsigned          neurons_done;
    logic [TAPS_W-1:0]    cfg_taps;
    logic [NEUR_W-1:0]    cfg_neurons;
    logic [BIAS_W-1:0]    cfg_bias;
    t_out_item            expected_acts[$];

    int err_count     = 0;
    int items_sent    = 0;
    int send_wait_max = 0;
    int recv_wait_max = 0;
    int quiet_cycles  = 0;

    local_window_neuron_mac_sigmoid dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 i_clk = ~i_clk;

    // exp(-num/den) in Q.31: truncated series of exp(-t/256), squared 8 times.
    function automatic longint unsigned exp_neg_frac(input longint unsigned num,
                                                     input longint unsigned den);
        longint unsigned y;
        longint unsigned term;
        longint unsigned v;
        longint          s;
        y    = ((num << 23) + den / 2) / den;
        s    = 64'sd2147483648;
        term = 64'd2147483648;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * y) >> 31) / 64'(n);
            if (n % 2 == 1) begin
                s = s - longint'(term);
            end else begin
                s = s + longint'(term);
            end
        end
        v = s;
        for (int i = 0; i < 8; i++) begin
            v = (v * v + 64'd1073741824) >> 31;
        end
        return v;
    endfunction

    // Sigmoid table over [-8,8), each entry taken at the left edge of its bin.
    function automatic void build_sigmoid_lut();
        longint unsigned pos;
        longint unsigned half;
        longint unsigned num;
        longint unsigned e;
        longint unsigned d;
        longint unsigned top;
        longint unsigned r;
        bit              nonneg;
        for (int k = 0; k < LUT_N; k++) begin
            pos    = 64'(16 * k);
            half   = 64'(8 * LUT_N);
            nonneg = pos >= half;
            num    = nonneg ? pos - half : half - pos;
            e      = exp_neg_frac(num, 64'(LUT_N));
            d      = 64'd2147483648 + e;
            top    = nonneg ? (64'd65536 << 31) : 64'd65536 * e;
            r      = (top + d / 2) / d;
            if (r > 64'd65535) begin
                r = 64'd65535;
            end
            sig_lut[k] = r[15:0];
        end
    endfunction

    // Taps actually used: zero counts as one, large values clip to the maximum.
    function automatic int unsigned taps_in_use();
        if (cfg_taps == 0) begin
            return 1;
        end
        if (cfg_taps > TAPS_CAP) begin
            return TAPS_CAP;
        end
        return 32'(cfg_taps);
    endfunction

    // Accumulates one pair; on the last tap of a neuron, produces its activation.
    function automatic bit neuron_step(input t_in_item it, output t_out_item res);
        longint      prod;
        longint      x;
        int unsigned eff_neurons;
        int          idx;
        bit          last;
        res     = '0;
        prod    = longint'(it.activation_in) * longint'($signed(it.weight));
        mac_sum = mac_sum + prod[ACC_W-1:0];
        if (taps_done + 1 < taps_in_use()) begin
            taps_done++;
            return 1'b0;
        end
        taps_done = 0;

        // Floor to Q.16, add the bias, then look up with saturation at both ends.
        x = (longint'($signed(mac_sum)) >>> FRAC_SH) + longint'($signed(cfg_bias));
        if (x < -X_EDGE) begin
            idx = 0;
        end else if (x >= X_EDGE) begin
            idx = LUT_N - 1;
        end else begin
            idx = int'(((x + X_EDGE) * LUT_N) >>> 20);
        end

        eff_neurons  = (cfg_neurons == 0) ? 1 : 32'(cfg_neurons);
        last         = neurons_done + 1 >= eff_neurons;
        neurons_done = last ? 0 : (neurons_done + 1) & 32'hFFFF;
        mac_sum      = '0;
        res.activation_out = sig_lut[idx];
        res.last_of_layer  = last;
        return 1'b1;
    endfunction

    // Idle cycles before an item; zero is drawn often so bursts occur too.
    function automatic int draw_wait(input int max_wait);
        if (max_wait == 0 || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return int'($urandom_range(0, max_wait));
    endfunction

    function automatic t_in_item make_pair(input logic [15:0] act, input logic [15:0] wgt);
        t_in_item it;
        it.activation_in = act;
        it.weight        = wgt;
        return it;
    endfunction

    // Random pair, biased toward the extremes and toward small weights.
    function automatic t_in_item random_pair();
        t_in_item it;
        int       r;
        it.activation_in = 16'($urandom);
        it.weight        = 16'($urandom);
        r = $urandom_range(0, 7);
        if (r == 0) begin
            it.activation_in = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else if (r == 1) begin
            it.weight = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        end else if (r == 2 || r == 3) begin
            it.weight = 16'($urandom_range(0, 4095)) - 16'd2048;
        end
        return it;
    endfunction

    // Sends one item and records the activation it completes, if any.
    task automatic send_pair(input t_in_item it);
        int        gap;
        t_out_item res;
        gap = draw_wait(send_wait_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        items_sent++;
        if (neuron_step(it, res)) begin
            expected_acts.push_back(res);
        end
    endtask

    task automatic send_neuron();
        repeat (taps_in_use()) send_pair(random_pair());
    endtask

    // Holds the input until every activation has come out and the pipe is empty.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_acts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One register write (setup cycle, then access cycle), then a read back.
    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] want_back;
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        want_back = '0;
        case (idx)
            REG_TAPS: begin
                cfg_taps  = value[TAPS_W-1:0];
                want_back = PDATA_W'(cfg_taps);
            end
            REG_LAYER_NEURONS: begin
                cfg_neurons = value[NEUR_W-1:0];
                want_back   = PDATA_W'(cfg_neurons);
            end
            REG_BIAS_Q16: begin
                cfg_bias  = value[BIAS_W-1:0];
                want_back = PDATA_W'(cfg_bias);
            end
            default: ;
        endcase

        // Read the same register: setup cycle, then access cycle.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== want_back) begin
            $error("prdata: expected %0d, actual %0d", want_back, prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_layer(input int taps, input int neurons, input logic [31:0] bias);
        write_reg(REG_TAPS, 32'(taps));
        write_reg(REG_LAYER_NEURONS, 32'(neurons));
        write_reg(REG_BIAS_Q16, bias);
    endtask

    // Reset values: three taps, bias of 0.1; the sum runs past the top of the table.
    task automatic test_reset_config();
        repeat (3) send_pair(make_pair(16'hFFFF, 16'h7FFF));
        send_pair(make_pair(16'h0000, 16'h0000));
        send_pair(make_pair(16'hFFFF, 16'h8000));
        send_pair(make_pair(16'h0001, 16'h0001));
    endtask

    // Single taps, every output last, bias at both extremes, and taps of zero.
    task automatic test_single_tap();
        set_layer(1, 0, 32'h007F_FFFF);
        send_pair(make_pair(16'h0000, 16'h0000));
        send_pair(make_pair(16'hFFFF, 16'h8000));
        set_layer(1, 0, 32'h0080_0000);
        send_pair(make_pair(16'h0000, 16'h0000));
        send_pair(make_pair(16'hFFFF, 16'h7FFF));
        set_layer(0, 1, 32'h0);
        send_pair(make_pair(16'h8000, 16'h1000));
        send_pair(make_pair(16'h0000, 16'h0000));
    endtask

    // Layer size lowered below the neurons already done: the next output is last.
    task automatic test_layer_lowered();
        set_layer(1, 6, 32'h0);
        repeat (4) send_pair(random_pair());
        set_layer(1, 2, 32'h0);
        repeat (3) send_pair(random_pair());
    endtask

    // Random phases of whole neurons, each under its own settings and idling.
    task automatic test_random();
        int          taps;
        int          neurons;
        logic [31:0] bias;
        int          count;
        int          r;
        while (items_sent < ITEM_GOAL) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                taps = 0;
            end else if (r == 1) begin
                taps = TAPS_CAP;
            end else if (r == 2) begin
                taps = $urandom_range(TAPS_CAP + 1, 127);
            end else begin
                taps = $urandom_range(1, 8);
            end
            r = $urandom_range(0, 7);
            if (r == 0) begin
                neurons = 0;
            end else if (r == 1) begin
                neurons = 65535;
            end else if (r == 2) begin
                neurons = 1;
            end else begin
                neurons = $urandom_range(2, 10);
            end
            r = $urandom_range(0, 7);
            if (r == 0) begin
                bias = 32'h0080_0000;
            end else if (r == 1) begin
                bias = 32'h007F_FFFF;
            end else if (r == 2) begin
                bias = $urandom & 32'h00FF_FFFF;
            end else begin
                bias = 32'($urandom_range(0, 1200000)) - 32'd600000;
            end
            set_layer(taps, neurons, bias);

            r = $urandom_range(0, 3);
            send_wait_max = (r == 1 || r == 3) ? WAIT_MAX : 0;
            recv_wait_max = (r == 2 || r == 3) ? WAIT_MAX : 0;

            count = (taps_in_use() > 8) ? $urandom_range(1, 2) : $urandom_range(1, 12);
            repeat (count) begin
                send_neuron();
                if ($urandom_range(0, 19) == 0) begin
                    wait_idle();
                end
            end
        end
    endtask

    initial begin
        build_sigmoid_lut();
        mac_sum      = '0;
        taps_done    = 0;
        neurons_done = 0;
        cfg_taps     = TAPS_W'(TAPS_AT_RST);
        cfg_neurons  = NEUR_W'(NEURONS_AT_RST);
        cfg_bias     = BIAS_W'(BIAS_AT_RST);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_single_tap();
        test_layer_lowered();
        test_random();
        wait_idle();

        if (err_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Output side: random stalls, then each accepted item is checked in order.
    initial begin
        t_out_item want;
        int        hold;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = draw_wait(recv_wait_max);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (expected_acts.size() == 0) begin
                $error("unexpected item: activation_out %0d last_of_layer %0d",
                       o_out_data.activation_out, o_out_data.last_of_layer);
                err_count++;
            end else begin
                want = expected_acts.pop_front();
                if (o_out_data.activation_out !== want.activation_out) begin
                    $error("activation_out: expected %0d, actual %0d",
                           want.activation_out, o_out_data.activation_out);
                    err_count++;
                end
                if (o_out_data.last_of_layer !== want.last_of_layer) begin
                    $error("last_of_layer: expected %0d, actual %0d",
                           want.last_of_layer, o_out_data.last_of_layer);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: too long without any accepted item or register access ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

endmodule
